/* sv/bsmq_pkg.sv */
`timescale 1ns / 1ps

package bsmq_pkg;

   localparam int DEPTH = 16;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [1:0] ACT_ENQUEUE = 2'd0;
   localparam logic [1:0] ACT_DEQUEUE = 2'd1;
   localparam logic [1:0] ACT_CLEAR   = 2'd2;
   localparam logic [1:0] ACT_QUERY   = 2'd3;

   localparam logic [1:0] STS_OK    = 2'd0;
   localparam logic [1:0] STS_FULL  = 2'd1;
   localparam logic [1:0] STS_EMPTY = 2'd2;

   typedef struct packed {
      logic [1:0]         action;
      logic [15:0]        item_index;
      logic signed [31:0] item_value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [4:0]         entry_count;
      logic [15:0]        min_index;
      logic signed [31:0] min_value;
      logic [15:0]        max_index;
      logic signed [31:0] max_value;
      logic               is_empty;
      logic               is_full;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic [15:0]        index;
   } entry_type;

   typedef struct packed {
      logic      enq_en;
      logic      deq_en;
      entry_type item;
   } cell_ctl_type;

endpackage

/* sv/bsmq_cell.sv */
`timescale 1ns / 1ps

module bsmq_cell import bsmq_pkg::*; (
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  logic         occupied,
   input  logic         left_ge,
   input  entry_type    left_data,
   input  entry_type    right_data,
   output logic         ge,
   output entry_type    data
);

   entry_type data_ff;
   entry_type data_in;

   // new item sorts after this entry
   assign ge = occupied && (ctl.item.value >= data_ff.value);

   always_comb begin
      data_in = data_ff;
      if (ctl.enq_en) begin
         if (!ge) begin
            data_in = left_ge ? ctl.item : left_data;
         end
      end else if (ctl.deq_en) begin
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

/* sv/bounded_sorted_min_queue.sv */
`timescale 1ns / 1ps
// Channel  Ports                          Direction  Contents
// request  req_valid/req_ready/req_data   in         req_type: action, index, value
// response rsp_valid/rsp_ready/rsp_data   out        rsp_type: status, count, min, max
// csr      csr_wr_en/csr_wr_data          in         capacity, 5 bits
//
// The cell chain updates at the accepting edge; the response register then loads
// from the chain once rsp_data is free (rsp_valid low or rsp_ready high).
// The next item is accepted once the previous response has entered rsp_data.
// Reset empties the queue and sets capacity to DEPTH; slot contents are not reset.
// A capacity write also empties the queue.

module bounded_sorted_min_queue import bsmq_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_wr_en,
   input  logic [4:0] csr_wr_data
);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] cap_ff, cap_in;
   logic             busy_ff, busy_in;
   logic [1:0]       status_ff, status_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   cell_ctl_type     ctl;
   entry_type        cell_data [DEPTH];
   logic             cell_ge [DEPTH];
   logic [CNT_W-1:0] last_cnt;
   logic [SLOT_W-1:0] last_slot;
   entry_type        max_entry;
   logic             accept;
   logic             full;
   logic             empty;
   logic             reject;
   logic             load_rsp;

   assign last_cnt  = count_ff - CNT_W'(1);
   assign last_slot = last_cnt[SLOT_W-1:0];
   assign max_entry = cell_data[last_slot];
   assign full      = (count_ff >= cap_ff);
   assign empty     = (count_ff == '0);
   assign reject    = full && !(req_data.item_value < max_entry.value);

   assign req_ready = !busy_ff;
   assign accept    = req_valid && !busy_ff;

   assign ctl.item.value = req_data.item_value;
   assign ctl.item.index = req_data.item_index;
   assign ctl.enq_en = accept && (req_data.action == ACT_ENQUEUE) && !reject;
   assign ctl.deq_en = accept && (req_data.action == ACT_DEQUEUE) && !empty;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic      left_ge;
      entry_type left_data;
      entry_type right_data;
      if (i == 0) begin : g_first
         assign left_ge   = 1'b1;
         assign left_data = ctl.item;
      end else begin : g_mid
         assign left_ge   = cell_ge[i-1];
         assign left_data = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_data = ctl.item;
      end else begin : g_inner
         assign right_data = cell_data[i+1];
      end
      bsmq_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .occupied   (count_ff > CNT_W'(i)),
         .left_ge    (left_ge),
         .left_data  (left_data),
         .right_data (right_data),
         .ge         (cell_ge[i]),
         .data       (cell_data[i])
      );
   end

   always_comb begin
      if (csr_wr_data == 5'd0) begin
         cap_in = CNT_W'(1);
      end else if (32'(csr_wr_data) > DEPTH) begin
         cap_in = CNT_W'(DEPTH);
      end else begin
         cap_in = CNT_W'(csr_wr_data);
      end
   end

   always_comb begin
      count_in  = count_ff;
      status_in = status_ff;
      busy_in   = busy_ff;
      if (accept) begin
         busy_in   = 1'b1;
         status_in = STS_OK;
         unique case (req_data.action)
            ACT_ENQUEUE: begin
               if (reject) begin
                  status_in = STS_FULL;
               end else if (!full) begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
            ACT_DEQUEUE: begin
               if (empty) begin
                  status_in = STS_EMPTY;
               end else begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
            ACT_CLEAR: begin
               count_in = '0;
            end
            ACT_QUERY: begin
               if (empty) begin
                  status_in = STS_EMPTY;
               end
            end
            default: begin
               status_in = STS_OK;
            end
         endcase
      end
      if (load_rsp) begin
         busy_in = 1'b0;
      end
      if (csr_wr_en) begin
         count_in = '0;
      end
   end

   assign load_rsp = busy_ff && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.status      = status_ff;
         rsp_data_in.entry_count = 5'(count_ff);
         rsp_data_in.is_empty    = empty;
         rsp_data_in.is_full     = (count_ff == cap_ff);
         if (empty) begin
            rsp_data_in.min_index = '0;
            rsp_data_in.min_value = '0;
            rsp_data_in.max_index = '0;
            rsp_data_in.max_value = '0;
         end else begin
            rsp_data_in.min_index = cell_data[0].index;
            rsp_data_in.min_value = cell_data[0].value;
            rsp_data_in.max_index = max_entry.index;
            rsp_data_in.max_value = max_entry.value;
         end
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cap_ff       <= CNT_W'(DEPTH);
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         cap_ff       <= csr_wr_en ? cap_in : cap_ff;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
